@@ hdl/ialu_pkg.sv @@
// Shared types and constants for the integer ALU with compare.
package ialu_pkg;

  localparam int IALU_DATA_W        = 16;  // port width of operand and result words
  localparam int IALU_SHAMT_W       = 5;   // port width of the shift count
  localparam int IALU_OP_W          = 4;   // port width of the operation code
  localparam int IALU_WIDTH_DEFAULT = 16;  // default datapath width

  typedef enum logic [IALU_OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_NEG = 4'd2,
    OP_ABS = 4'd3,
    OP_SHR = 4'd4,
    OP_SHL = 4'd5,
    OP_EQ  = 4'd6,
    OP_GT  = 4'd7,
    OP_LT  = 4'd8,
    OP_LE  = 4'd9,
    OP_GE  = 4'd10,
    OP_MAX = 4'd11,
    OP_MIN = 4'd12
  } op_t;

  // Per-stage control that travels with the data.
  typedef struct packed {
    logic valid;
    op_t  op;
  } stage_ctl_t;

  // Compare and sign flags produced by the execute stage.
  typedef struct packed {
    logic eq;
    logic gt;
    logic lt;
    logic sign;
  } cmp_flags_t;

endpackage

@@ hdl/ialu_decode.sv @@
// Stage 1: capture the transaction and size the operands to the datapath width.
module ialu_decode #(
  parameter int WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ialu_pkg::IALU_OP_W-1:0]    in_operation,
  input  logic [ialu_pkg::IALU_DATA_W-1:0]  in_operand_a,
  input  logic [ialu_pkg::IALU_DATA_W-1:0]  in_operand_b,
  input  logic [ialu_pkg::IALU_SHAMT_W-1:0] in_shift_count,
  input  logic                            dn_ready,
  output ialu_pkg::stage_ctl_t            ctl_o,
  output logic [WIDTH-1:0]                a_o,
  output logic [WIDTH-1:0]                b_o,
  output logic [ialu_pkg::IALU_SHAMT_W-1:0] k_o
);
  import ialu_pkg::*;

  logic                    valid_r, valid_nxt;
  op_t                     op_r;
  logic [WIDTH-1:0]        a_r, b_r;
  logic [IALU_SHAMT_W-1:0] k_r;

  assign in_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = in_ready ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Zero-extend or truncate to WIDTH, as the low WIDTH bits are all that count.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r <= op_t'(in_operation);
      a_r  <= WIDTH'(in_operand_a);
      b_r  <= WIDTH'(in_operand_b);
      k_r  <= in_shift_count;
    end
  end

  assign ctl_o = '{valid: valid_r, op: op_r};
  assign a_o   = a_r;
  assign b_o   = b_r;
  assign k_o   = k_r;

endmodule

@@ hdl/ialu_exec.sv @@
// Stage 2: adders, negate, barrel shifters and the compares.
module ialu_exec #(
  parameter int WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ialu_pkg::stage_ctl_t              ctl_i,
  output logic                              up_ready,
  input  logic [WIDTH-1:0]                  a_i,
  input  logic [WIDTH-1:0]                  b_i,
  input  logic [ialu_pkg::IALU_SHAMT_W-1:0] k_i,
  input  logic                              dn_ready,
  output ialu_pkg::stage_ctl_t              ctl_o,
  output ialu_pkg::cmp_flags_t              flags_o,
  output logic [WIDTH-1:0]                  a_o,
  output logic [WIDTH-1:0]                  b_o,
  output logic [WIDTH-1:0]                  sum_o,
  output logic [WIDTH-1:0]                  diff_o,
  output logic [WIDTH-1:0]                  neg_o,
  output logic [WIDTH-1:0]                  shr_o,
  output logic [WIDTH-1:0]                  shl_o
);
  import ialu_pkg::*;

  logic       valid_r, valid_nxt;
  op_t        op_r;
  cmp_flags_t flags_r, flags_nxt;
  logic [WIDTH-1:0] a_r, b_r, sum_r, diff_r, neg_r, shr_r, shl_r;
  logic [WIDTH-1:0] sum_nxt, diff_nxt, neg_nxt, shr_nxt, shl_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? ctl_i.valid : valid_r;
  end

  always_comb begin
    sum_nxt  = a_i + b_i;
    diff_nxt = a_i - b_i;
    neg_nxt  = {WIDTH{1'b0}} - a_i;
    // Arithmetic shift saturates to all sign bits once k reaches WIDTH.
    shr_nxt  = $unsigned($signed(a_i) >>> k_i);
    // Sign bit held, low bits shifted with zero fill.
    shl_nxt  = {a_i[WIDTH-1], a_i[WIDTH-2:0] << k_i};
    // Ordering ignores the top bit.
    flags_nxt.eq   = (a_i == b_i);
    flags_nxt.gt   = (a_i[WIDTH-2:0] > b_i[WIDTH-2:0]);
    flags_nxt.lt   = (a_i[WIDTH-2:0] < b_i[WIDTH-2:0]);
    flags_nxt.sign = a_i[WIDTH-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && ctl_i.valid) begin
      op_r    <= ctl_i.op;
      flags_r <= flags_nxt;
      a_r     <= a_i;
      b_r     <= b_i;
      sum_r   <= sum_nxt;
      diff_r  <= diff_nxt;
      neg_r   <= neg_nxt;
      shr_r   <= shr_nxt;
      shl_r   <= shl_nxt;
    end
  end

  assign ctl_o   = '{valid: valid_r, op: op_r};
  assign flags_o = flags_r;
  assign a_o     = a_r;
  assign b_o     = b_r;
  assign sum_o   = sum_r;
  assign diff_o  = diff_r;
  assign neg_o   = neg_r;
  assign shr_o   = shr_r;
  assign shl_o   = shl_r;

endmodule

@@ hdl/ialu_select.sv @@
// Stage 3: pick the result by operation code into the output register.
module ialu_select #(
  parameter int WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ialu_pkg::stage_ctl_t             ctl_i,
  output logic                             up_ready,
  input  ialu_pkg::cmp_flags_t             flags_i,
  input  logic [WIDTH-1:0]                 a_i,
  input  logic [WIDTH-1:0]                 b_i,
  input  logic [WIDTH-1:0]                 sum_i,
  input  logic [WIDTH-1:0]                 diff_i,
  input  logic [WIDTH-1:0]                 neg_i,
  input  logic [WIDTH-1:0]                 shr_i,
  input  logic [WIDTH-1:0]                 shl_i,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ialu_pkg::IALU_DATA_W-1:0] out_result_word
);
  import ialu_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [IALU_DATA_W-1:0] result_r, result_nxt;
  logic [WIDTH-1:0]       res_w;

  assign up_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = up_ready ? ctl_i.valid : valid_r;
  end

  always_comb begin
    case (ctl_i.op)
      OP_ADD:  res_w = sum_i;
      OP_SUB:  res_w = diff_i;
      OP_NEG:  res_w = neg_i;
      OP_ABS:  res_w = flags_i.sign ? neg_i : a_i;
      OP_SHR:  res_w = shr_i;
      OP_SHL:  res_w = shl_i;
      OP_EQ:   res_w = WIDTH'(flags_i.eq);
      OP_GT:   res_w = WIDTH'(flags_i.gt);
      OP_LT:   res_w = WIDTH'(flags_i.lt);
      OP_LE:   res_w = WIDTH'(!flags_i.gt);
      OP_GE:   res_w = WIDTH'(!flags_i.lt);
      OP_MAX:  res_w = flags_i.gt ? a_i : b_i;
      OP_MIN:  res_w = flags_i.lt ? a_i : b_i;
      default: res_w = {WIDTH{1'b0}};
    endcase
    result_nxt = IALU_DATA_W'(res_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && ctl_i.valid) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_word = result_r;

endmodule

@@ hdl/integer_alu_with_compare.sv @@
// Top level of the integer ALU with compare: three-stage pipeline.
//
// Integer ALU with compare. Each input transaction carries an operation code, two
// WIDTH-bit operand words and a shift count; it yields exactly one result transaction.
// Operations: add, sub (modulo 2^WIDTH), neg, abs (on the top bit), arithmetic shift
// right, shift left holding the sign bit, and eq, gt, lt, le, ge, max, min. Equality
// looks at all WIDTH bits; the ordering compares use only the low WIDTH-1 bits, unsigned.
// Compare results sit in bit 0 with all other bits zero; undefined opcodes return zero.
// Operands enter on 16-bit ports and only their low WIDTH bits are used; the result
// port carries the low 16 bits of the WIDTH-bit result.
// Timing: three register stages (decode, execute, select); a transaction passes them in
// that order and raises out_valid once held in select. One transaction is accepted per
// cycle unless a stall has backed up to the input. Each stage holds its own valid bit
// and loads whenever it is empty or its successor moves, so a stall at out_ready backs
// up stage by stage and empty stages keep filling behind it.

module integer_alu_with_compare #(
  parameter int WIDTH = ialu_pkg::IALU_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ialu_pkg::IALU_OP_W-1:0]    in_operation,
  input  logic [ialu_pkg::IALU_DATA_W-1:0]  in_operand_a,
  input  logic [ialu_pkg::IALU_DATA_W-1:0]  in_operand_b,
  input  logic [ialu_pkg::IALU_SHAMT_W-1:0] in_shift_count,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ialu_pkg::IALU_DATA_W-1:0]  out_result_word
);
  import ialu_pkg::*;

  // decode -> execute
  stage_ctl_t              dec_ctl;
  logic [WIDTH-1:0]        dec_a, dec_b;
  logic [IALU_SHAMT_W-1:0] dec_k;
  logic                    exe_ready;

  // execute -> select
  stage_ctl_t       exe_ctl;
  cmp_flags_t       exe_flags;
  logic [WIDTH-1:0] exe_a, exe_b, exe_sum, exe_diff, exe_neg, exe_shr, exe_shl;
  logic             sel_ready;

  // Stage 1: register the transaction, size operands to WIDTH.
  ialu_decode #(
    .WIDTH (WIDTH)
  ) u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .in_shift_count (in_shift_count),
    .dn_ready       (exe_ready),
    .ctl_o          (dec_ctl),
    .a_o            (dec_a),
    .b_o            (dec_b),
    .k_o            (dec_k)
  );

  // Stage 2: every candidate result and the compare flags, computed in parallel.
  ialu_exec #(
    .WIDTH (WIDTH)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (dec_ctl),
    .up_ready (exe_ready),
    .a_i      (dec_a),
    .b_i      (dec_b),
    .k_i      (dec_k),
    .dn_ready (sel_ready),
    .ctl_o    (exe_ctl),
    .flags_o  (exe_flags),
    .a_o      (exe_a),
    .b_o      (exe_b),
    .sum_o    (exe_sum),
    .diff_o   (exe_diff),
    .neg_o    (exe_neg),
    .shr_o    (exe_shr),
    .shl_o    (exe_shl)
  );

  // Stage 3: opcode mux into the output register.
  ialu_select #(
    .WIDTH (WIDTH)
  ) u_select (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl_i           (exe_ctl),
    .up_ready        (sel_ready),
    .flags_i         (exe_flags),
    .a_i             (exe_a),
    .b_i             (exe_b),
    .sum_i           (exe_sum),
    .diff_i          (exe_diff),
    .neg_i           (exe_neg),
    .shr_i           (exe_shr),
    .shl_i           (exe_shl),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_word (out_result_word)
  );

endmodule

@@ tb/integer_alu_with_compare_test.sv @@
// Self-checking testbench for the integer ALU with compare: queue-fed driver, predictor, monitor.
module integer_alu_with_compare_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ialu_pkg::*;

  // Datapath width of the instance; it matches the 16-bit data ports.
  localparam int W         = IALU_WIDTH_DEFAULT;
  localparam int DW        = IALU_DATA_W;
  localparam int KW        = IALU_SHAMT_W;
  localparam int OPW       = IALU_OP_W;
  localparam int SHIFT_MAX = W;
  // Three register stages; a few spare cycles after the last result.
  localparam int TAIL_CYCLES = 8;
  // Watchdog bound on the whole run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;

  // Opcodes past OP_MIN are undefined and must return zero.
  localparam logic [OPW-1:0] OP_UNDEF_LO = 4'd13;
  localparam logic [OPW-1:0] OP_UNDEF_HI = 4'd15;

  localparam logic [DW-1:0] WORD_ZERO = '0;
  localparam logic [DW-1:0] WORD_ONES = '1;
  localparam logic [DW-1:0] WORD_MSB  = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] WORD_MAXP = {1'b0, {(DW-1){1'b1}}};

  typedef struct {
    logic [OPW-1:0] op;
    logic [DW-1:0]  a;
    logic [DW-1:0]  b;
    logic [KW-1:0]  k;
  } alu_txn_t;

  typedef struct {
    alu_txn_t      txn;
    logic [DW-1:0] word;
  } alu_expect_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic            in_valid       = 1'b0;
  logic            in_ready;
  logic [OPW-1:0]  in_operation   = '0;
  logic [DW-1:0]   in_operand_a   = '0;
  logic [DW-1:0]   in_operand_b   = '0;
  logic [KW-1:0]   in_shift_count = '0;
  logic            out_valid;
  logic            out_ready      = 1'b0;
  logic [DW-1:0]   out_result_word;

  alu_txn_t    pending_ops[$];      // stimulus not yet handed to the driver
  alu_expect_t awaited_results[$];  // accepted transactions, oldest first

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold        = 1'b0;  // long receiver hold-off, owned by the stimulus process
  logic        in_fire        = 1'b0;  // input transaction accepted at the last rising edge
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  integer_alu_with_compare #(.WIDTH(W)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .in_shift_count (in_shift_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_word(out_result_word)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: expected result word for one transaction.
  // Ordering compares look only at the low W-1 bits, unsigned; eq uses all bits.
  // ---------------------------------------------------------------------------
  function automatic logic [DW-1:0] compute_result(alu_txn_t t);
    logic [W-1:0]        r;
    logic signed [W-1:0] sa;
    logic                sign;
    logic                a_gt_b;
    logic                b_gt_a;
    sign   = t.a[W-1];
    sa     = t.a;
    a_gt_b = t.a[W-2:0] > t.b[W-2:0];
    b_gt_a = t.b[W-2:0] > t.a[W-2:0];
    r      = '0;
    case (t.op)
      OP_ADD: r = t.a + t.b;
      OP_SUB: r = t.a - t.b;
      OP_NEG: r = WORD_ZERO - t.a;
      OP_ABS: r = sign ? WORD_ZERO - t.a : t.a;
      OP_SHR: begin
        if (t.k >= SHIFT_MAX) r = {W{sign}};
        else r = sa >>> t.k;
      end
      // Sign bit held; low bits shifted with zero fill, overflow dropped.
      OP_SHL: r = {sign, t.a[W-2:0] << t.k};
      OP_EQ:  r = {{(W-1){1'b0}}, t.a == t.b};
      OP_GT:  r = {{(W-1){1'b0}}, a_gt_b};
      OP_LT:  r = {{(W-1){1'b0}}, b_gt_a};
      OP_LE:  r = {{(W-1){1'b0}}, !a_gt_b};
      OP_GE:  r = {{(W-1){1'b0}}, !b_gt_a};
      OP_MAX: r = a_gt_b ? t.a : t.b;
      OP_MIN: r = b_gt_a ? t.a : t.b;
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: launches the next pending transaction at the falling edge and holds
  // it until the rising edge where in_valid and in_ready were both high.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    alu_txn_t nxt;
    logic     drive_v;
    drive_v = in_valid && !in_fire;
    if (rst_n && !drive_v && pending_ops.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      nxt            = pending_ops.pop_front();
      in_operation   <= nxt.op;
      in_operand_a   <= nxt.a;
      in_operand_b   <= nxt.b;
      in_shift_count <= nxt.k;
      drive_v        = 1'b1;
    end
    in_valid <= drive_v;
  end

  // Receiver: random stalls, or a solid hold-off while rx_hold is up.
  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: records accepted inputs with their prediction, then checks each
  // accepted result against the oldest outstanding prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alu_txn_t    t;
    alu_expect_t e;
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      t.op = in_operation;
      t.a  = in_operand_a;
      t.b  = in_operand_b;
      t.k  = in_shift_count;
      e.txn  = t;
      e.word = compute_result(t);
      awaited_results.push_back(e);
    end
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_result_word));
      end else begin
        e = awaited_results.pop_front();
        if (out_result_word !== e.word)
          report_mismatch($sformatf("op %0d a %h b %h k %0d: result_word %h, want %h",
                                    e.txn.op, e.txn.a, e.txn.b, e.txn.k,
                                    out_result_word, e.word));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [OPW-1:0] op, input logic [DW-1:0] a,
                           input logic [DW-1:0] b, input logic [KW-1:0] k);
    alu_txn_t t;
    t.op = op;
    t.a  = a;
    t.b  = b;
    t.k  = k;
    pending_ops.push_back(t);
  endtask

  // Corner-heavy operand mix.
  function automatic logic [DW-1:0] pick_word();
    case ($urandom_range(7))
      0: return WORD_ZERO;
      1: return WORD_ONES;
      2: return WORD_MSB;
      3: return WORD_MAXP;
      4: return 16'h0001;
      default: return DW'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic fill_random(input int unsigned n);
    logic [OPW-1:0] op;
    logic [DW-1:0]  a;
    logic [DW-1:0]  b;
    logic [KW-1:0]  k;
    repeat (n) begin
      if ($urandom_range(99) < 94) op = OPW'($urandom_range(OP_MIN));
      else op = OPW'(OP_UNDEF_LO + $urandom_range(OP_UNDEF_HI - OP_UNDEF_LO));
      a = pick_word();
      // Compares need near and equal operands to exercise the tie paths.
      case ($urandom_range(5))
        0: b = a;
        1: b = a ^ WORD_MSB;
        2: b = a + 16'h0001;
        default: b = pick_word();
      endcase
      if ($urandom_range(3) == 0) k = KW'(SHIFT_MAX - $urandom_range(1));
      else k = KW'($urandom_range(SHIFT_MAX));
      push_item(op, a, b, k);
    end
  endtask

  // Sender pause: nothing new is offered until every prediction is retired.
  task automatic wait_results_drained();
    while (pending_ops.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    fill_random(n);
    wait_results_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners, back to back.
    push_item(OP_ADD, WORD_ONES, 16'h0001, 5'd0);
    push_item(OP_ADD, WORD_MAXP, 16'h0001, 5'd0);
    push_item(OP_SUB, WORD_ZERO, 16'h0001, 5'd0);
    push_item(OP_SUB, WORD_MSB,  16'h0001, 5'd0);
    // Most negative value stays put under neg and abs.
    push_item(OP_NEG, WORD_MSB,  WORD_ONES, 5'd0);
    push_item(OP_NEG, 16'h0001,  WORD_ZERO, 5'd0);
    push_item(OP_ABS, WORD_MSB,  WORD_ZERO, 5'd0);
    push_item(OP_ABS, WORD_ONES, WORD_ZERO, 5'd0);
    push_item(OP_ABS, WORD_MAXP, WORD_ONES, 5'd0);
    // Shifts at and just below the width.
    push_item(OP_SHR, WORD_MSB,  WORD_ZERO, 5'd16);
    push_item(OP_SHR, 16'h8001,  WORD_ZERO, 5'd15);
    push_item(OP_SHR, WORD_MAXP, WORD_ZERO, 5'd16);
    push_item(OP_SHR, 16'h4000,  WORD_ZERO, 5'd0);
    push_item(OP_SHL, WORD_ONES, WORD_ZERO, 5'd16);
    push_item(OP_SHL, 16'hC001,  WORD_ZERO, 5'd15);
    push_item(OP_SHL, 16'h0001,  WORD_ZERO, 5'd14);
    // Compares: top bit counts for eq only.
    push_item(OP_EQ,  16'h1234,  16'h1234,  5'd0);
    push_item(OP_EQ,  WORD_MSB,  WORD_ZERO, 5'd0);
    push_item(OP_GT,  16'h8001,  16'h0002,  5'd0);
    push_item(OP_LT,  WORD_ONES, WORD_MAXP, 5'd0);
    push_item(OP_LE,  16'h8005,  16'h0005,  5'd0);
    push_item(OP_GE,  WORD_ZERO, WORD_ONES, 5'd0);
    push_item(OP_MAX, WORD_MSB,  WORD_MAXP, 5'd0);
    push_item(OP_MIN, 16'h0001,  16'h8001,  5'd0);
    // Undefined opcodes return zero.
    push_item(OP_UNDEF_LO, WORD_ONES, WORD_ONES, 5'd16);
    push_item(OP_UNDEF_HI, WORD_ONES, WORD_ONES, 5'd16);
    wait_results_drained();

    run_phase(0,  0,  200);   // full rate both sides
    run_phase(68, 0,  150);   // sparse sender
    run_phase(0,  68, 150);   // stalling receiver
    run_phase(29, 29, 200);   // both idle

    // Backpressure: receiver blocks long enough that the pipeline fills and
    // in_ready drops while the sender keeps offering.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fill_random(60);
    rx_hold = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
    wait_results_drained();

    run_phase(0, 0, 100);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
